/* design/msd_pkg.sv */
// Shared types, constants and lookup functions for the Morse symbol decoder.
package msd_pkg;

  localparam int MaxSymbolDef = 8;
  localparam int FifoDepth    = 4;
  localparam int FifoAw       = $clog2(FifoDepth);

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharQmark = 8'h3F;

  localparam logic [3:0] TermLenReset = 4'd3;
  localparam logic [3:0] SepCountMax  = 4'd15;

  localparam logic [2:0] StepChar = 3'd0;
  localparam logic [2:0] StepEndFirst = 3'd1;
  localparam logic [2:0] StepEndLast  = 3'd5;

  typedef struct packed {
    logic       has_char;
    logic [7:0] ch;
    logic       has_end;
  } cmd_t;

  function automatic logic [7:0] decode_symbol(input logic [2:0] len, input logic [4:0] bits);
    logic [7:0] c;
    unique case ({len, bits})
      {3'd2, 5'b00001}: c = "A";
      {3'd4, 5'b01000}: c = "B";
      {3'd4, 5'b01010}: c = "C";
      {3'd3, 5'b00100}: c = "D";
      {3'd1, 5'b00000}: c = "E";
      {3'd4, 5'b00010}: c = "F";
      {3'd3, 5'b00110}: c = "G";
      {3'd4, 5'b00000}: c = "H";
      {3'd2, 5'b00000}: c = "I";
      {3'd4, 5'b00111}: c = "J";
      {3'd3, 5'b00101}: c = "K";
      {3'd4, 5'b00100}: c = "L";
      {3'd2, 5'b00011}: c = "M";
      {3'd2, 5'b00010}: c = "N";
      {3'd3, 5'b00111}: c = "O";
      {3'd4, 5'b00110}: c = "P";
      {3'd4, 5'b01101}: c = "Q";
      {3'd3, 5'b00010}: c = "R";
      {3'd3, 5'b00000}: c = "S";
      {3'd1, 5'b00001}: c = "T";
      {3'd3, 5'b00001}: c = "U";
      {3'd4, 5'b00001}: c = "V";
      {3'd3, 5'b00011}: c = "W";
      {3'd4, 5'b01001}: c = "X";
      {3'd4, 5'b01011}: c = "Y";
      {3'd4, 5'b01100}: c = "Z";
      {3'd5, 5'b11111}: c = "0";
      {3'd5, 5'b01111}: c = "1";
      {3'd5, 5'b00111}: c = "2";
      {3'd5, 5'b00011}: c = "3";
      {3'd5, 5'b00001}: c = "4";
      {3'd5, 5'b00000}: c = "5";
      {3'd5, 5'b10000}: c = "6";
      {3'd5, 5'b11000}: c = "7";
      {3'd5, 5'b11100}: c = "8";
      {3'd5, 5'b11110}: c = "9";
      default:          c = CharQmark;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] end_char(input logic [2:0] step);
    logic [7:0] c;
    unique case (step)
      3'd1:    c = "[";
      3'd2:    c = "E";
      3'd3:    c = "N";
      3'd4:    c = "D";
      3'd5:    c = "]";
      default: c = CharQmark;
    endcase
    return c;
  endfunction

endpackage

/* design/msd_front.sv */
// Front end: accepts text bytes, tracks symbol and separator state, issues commands.
module msd_front import msd_pkg::*; #(
  parameter int MaxSymbol = MaxSymbolDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       in_fire_i,
  input  logic [7:0] in_byte_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o
);

  localparam int LenW = $clog2(MaxSymbol + 1);

  logic [3:0]      term_len_q;
  logic [7:0]      bits_q, bits_d;
  logic [LenW-1:0] len_q, len_d;
  logic            ovf_q, ovf_d;
  logic [3:0]      sep_q, sep_d;
  logic            stop_q, stop_d;

  logic       is_elem;
  logic [3:0] sep_inc;
  logic [7:0] dec_char;

  assign is_elem = (in_byte_i == CharDot) || (in_byte_i == CharDash);
  assign sep_inc = (sep_q < SepCountMax) ? sep_q + 4'd1 : sep_q;
  assign dec_char = (ovf_q || (len_q > LenW'(5))) ? CharQmark
                                                  : decode_symbol(len_q[2:0], bits_q[4:0]);

  always_comb begin
    bits_d = bits_q;
    len_d  = len_q;
    ovf_d  = ovf_q;
    sep_d  = sep_q;
    stop_d = stop_q;
    cmd_o.has_char = 1'b0;
    cmd_o.ch       = dec_char;
    cmd_o.has_end  = 1'b0;
    if (stop_q) begin
      if (in_byte_i == CharNul) begin
        stop_d = 1'b0;
        bits_d = '0;
        len_d  = '0;
        ovf_d  = 1'b0;
        sep_d  = '0;
      end
    end else if (is_elem) begin
      if (len_q < LenW'(MaxSymbol)) begin
        bits_d = {bits_q[6:0], in_byte_i == CharDash};
        len_d  = len_q + LenW'(1);
      end else begin
        ovf_d = 1'b1;
      end
      sep_d = '0;
    end else begin
      cmd_o.has_char = (len_q != '0);
      bits_d = '0;
      len_d  = '0;
      ovf_d  = 1'b0;
      sep_d  = sep_inc;
      cmd_o.has_end = (sep_inc == term_len_q);
      stop_d = cmd_o.has_end;
      if (in_byte_i == CharNul) begin
        sep_d  = '0;
        stop_d = 1'b0;
      end
    end
  end

  assign cmd_push_o = in_fire_i && (cmd_o.has_char || cmd_o.has_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_len_q <= TermLenReset;
      bits_q     <= '0;
      len_q      <= '0;
      ovf_q      <= 1'b0;
      sep_q      <= '0;
      stop_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        term_len_q <= cfg_wdata_i;
      end
      if (in_fire_i) begin
        bits_q <= bits_d;
        len_q  <= len_d;
        ovf_q  <= ovf_d;
        sep_q  <= sep_d;
        stop_q <= stop_d;
      end
    end
  end

endmodule

/* design/msd_fifo.sv */
// Small command queue between the front and back ends.
module msd_fifo import msd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  cmd_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoAw:0]   count_q;

  assign full_o  = (count_q == (FifoAw + 1)'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FifoAw'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FifoAw'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (FifoAw + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (FifoAw + 1)'(1);
      end
    end
  end

endmodule

/* design/msd_back.sv */
// Back end: expands queued commands into output characters, one per cycle unless stalled.
module msd_back import msd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,
  output logic       m_axis_tlast_o
);

  logic [2:0] step_q, step_d;
  logic       valid_q;
  logic [7:0] data_q;
  logic       last_q;

  logic [2:0] eff_step;
  logic [7:0] ch;
  logic       is_last;
  logic       go;

  assign eff_step = ((step_q == StepChar) && !head_i.has_char) ? StepEndFirst : step_q;
  assign ch       = (eff_step == StepChar) ? head_i.ch : end_char(eff_step);
  assign is_last  = (eff_step == StepEndLast) || ((eff_step == StepChar) && !head_i.has_end);
  assign go       = (!valid_q || m_axis_tready_i) && !empty_i;
  assign pop_o    = go && is_last;
  assign step_d   = is_last ? StepChar : eff_step + 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= StepChar;
    end else if (go) begin
      valid_q <= 1'b1;
      step_q  <= step_d;
    end else if (m_axis_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      data_q <= ch;
      last_q <= is_last;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;

endmodule

/* design/morse_symbol_decoder_core.sv */
// Top level of the Morse symbol decoder: front end, command queue, back end.
// Path: a byte's command is queued, then its first output character is registered.
// Throughput: one input byte per cycle while the 4-entry command queue has room;
// output runs one char per cycle unless stalled, up to six per byte, set by the back end.
// Reset: asynchronous, active low; clears control state, terminator length returns to 3.
module morse_symbol_decoder_core import msd_pkg::*; #(
  parameter int MaxSymbol = MaxSymbolDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,      // separator run that ends the message
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] text_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_char
  output logic       m_axis_tlast_o    // run_last
);

  logic in_fire;
  logic cmd_push;
  cmd_t cmd;
  logic fifo_full;
  logic fifo_empty;
  logic fifo_pop;
  cmd_t fifo_head;

  assign s_axis_tready_o = !fifo_full;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  msd_front #(
    .MaxSymbol(MaxSymbol)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_fire_i  (in_fire),
    .in_byte_i  (s_axis_tdata_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd)
  );

  msd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_push),
    .push_data_i(cmd),
    .full_o     (fifo_full),
    .pop_i      (fifo_pop),
    .empty_o    (fifo_empty),
    .head_o     (fifo_head)
  );

  msd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (fifo_head),
    .empty_i        (fifo_empty),
    .pop_o          (fifo_pop),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule
